/* hdl/hjn_pkg.sv */
// hjn_pkg: shared types, constants and the jamo conversion table for the
// hangul jamo normalizer pipeline. No dependencies.
`timescale 1ns / 1ps

package hjn_pkg;

    typedef logic [15:0] t_unit;
    typedef logic [1:0]  t_class;
    typedef logic [6:0]  t_jamo_idx;

    // script class codes
    localparam t_class CLS_DIGIT   = 2'd0;
    localparam t_class CLS_ENGLISH = 2'd1;
    localparam t_class CLS_HANGUL  = 2'd2;
    localparam t_class CLS_OTHER   = 2'd3;

    // halfwidth hangul block
    localparam t_unit HW_LO = 16'hFFA0;
    localparam t_unit HW_HI = 16'hFFDC;
    localparam logic [7:0] HW_BRK_0 = 8'hBF;
    localparam logic [7:0] HW_BRK_1 = 8'hC8;
    localparam logic [7:0] HW_BRK_2 = 8'hD0;
    localparam logic [7:0] HW_BRK_3 = 8'hD8;
    localparam logic [7:0] HW_OFS_0 = 8'h70;
    localparam logic [7:0] HW_OFS_1 = 8'h73;
    localparam logic [7:0] HW_OFS_2 = 8'h75;
    localparam logic [7:0] HW_OFS_3 = 8'h77;
    localparam logic [7:0] HW_OFS_4 = 8'h79;
    localparam logic [7:0] COMPAT_HI_BYTE = 8'h31;

    // compatibility jamo block
    localparam t_unit COMPAT_LO = 16'h3130;
    localparam t_unit COMPAT_HI = 16'h318F;

    // other hangul ranges
    localparam logic [7:0] CONJ_HI_BYTE = 8'h11;
    localparam t_unit EXT_A_LO = 16'hA960;
    localparam t_unit EXT_A_HI = 16'hA97F;
    localparam t_unit EXT_B_LO = 16'hD7B0;
    localparam t_unit EXT_B_HI = 16'hD7FF;

    // ascii classes
    localparam t_unit DIGIT_LO = 16'h0030;
    localparam t_unit DIGIT_HI = 16'h0039;
    localparam t_unit ENG_LO   = 16'h0041;
    localparam t_unit ENG_HI   = 16'h007A;

    // stage 1 to stage 2
    typedef struct packed {
        t_unit  unit;
        t_class cls;
        logic   last;
    } t_s1;

    // stage 2 to stage 3
    typedef struct packed {
        t_unit     unit;
        t_jamo_idx idx;
        logic      in_jamo;
        t_class    cls;
        logic      last;
    } t_s2;

    // conjoining jamo for compatibility jamo 3130+idx, zero when unmapped
    function automatic t_unit jamo_lookup(input t_jamo_idx idx);
        t_unit m;
        case (idx)
            7'd0:  m = 16'h0000; 7'd1:  m = 16'h1100; 7'd2:  m = 16'h1101; 7'd3:  m = 16'h11AA;
            7'd4:  m = 16'h1102; 7'd5:  m = 16'h11AC; 7'd6:  m = 16'h11AD; 7'd7:  m = 16'h1103;
            7'd8:  m = 16'h1104; 7'd9:  m = 16'h1105; 7'd10: m = 16'h11B0; 7'd11: m = 16'h11B1;
            7'd12: m = 16'h11B2; 7'd13: m = 16'h11B3; 7'd14: m = 16'h11B4; 7'd15: m = 16'h11B5;
            7'd16: m = 16'h111A; 7'd17: m = 16'h1106; 7'd18: m = 16'h1107; 7'd19: m = 16'h1108;
            7'd20: m = 16'h1121; 7'd21: m = 16'h1109; 7'd22: m = 16'h110A; 7'd23: m = 16'h110B;
            7'd24: m = 16'h110C; 7'd25: m = 16'h110D; 7'd26: m = 16'h110E; 7'd27: m = 16'h110F;
            7'd28: m = 16'h1110; 7'd29: m = 16'h1111; 7'd30: m = 16'h1112; 7'd31: m = 16'h1161;
            7'd32: m = 16'h1162; 7'd33: m = 16'h1163; 7'd34: m = 16'h1164; 7'd35: m = 16'h1165;
            7'd36: m = 16'h1166; 7'd37: m = 16'h1167; 7'd38: m = 16'h1168; 7'd39: m = 16'h1169;
            7'd40: m = 16'h116A; 7'd41: m = 16'h116B; 7'd42: m = 16'h116C; 7'd43: m = 16'h116D;
            7'd44: m = 16'h116E; 7'd45: m = 16'h116F; 7'd46: m = 16'h1170; 7'd47: m = 16'h1171;
            7'd48: m = 16'h1172; 7'd49: m = 16'h1173; 7'd50: m = 16'h1174; 7'd51: m = 16'h1175;
            7'd52: m = 16'h1160; 7'd53: m = 16'h1114; 7'd54: m = 16'h1115; 7'd55: m = 16'h11C7;
            7'd56: m = 16'h11C8; 7'd57: m = 16'h11CC; 7'd58: m = 16'h11CE; 7'd59: m = 16'h11D3;
            7'd60: m = 16'h11D7; 7'd61: m = 16'h11D9; 7'd62: m = 16'h111C; 7'd63: m = 16'h11DD;
            7'd64: m = 16'h11DF; 7'd65: m = 16'h111D; 7'd66: m = 16'h111E; 7'd67: m = 16'h1120;
            7'd68: m = 16'h1122; 7'd69: m = 16'h1123; 7'd70: m = 16'h1127; 7'd71: m = 16'h1129;
            7'd72: m = 16'h112B; 7'd73: m = 16'h112C; 7'd74: m = 16'h112D; 7'd75: m = 16'h112E;
            7'd76: m = 16'h112F; 7'd77: m = 16'h1132; 7'd78: m = 16'h1136; 7'd79: m = 16'h1140;
            7'd80: m = 16'h1147; 7'd81: m = 16'h114C; 7'd82: m = 16'h11F1; 7'd83: m = 16'h11F2;
            7'd84: m = 16'h1157; 7'd85: m = 16'h1158; 7'd86: m = 16'h1159; 7'd87: m = 16'h1184;
            7'd88: m = 16'h1185; 7'd89: m = 16'h1188; 7'd90: m = 16'h1191; 7'd91: m = 16'h1192;
            7'd92: m = 16'h1194; 7'd93: m = 16'h119E; 7'd94: m = 16'h11A1;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

/* hdl/hjn_front.sv */
// hjn_front: stage 1, script class of the original unit and halfwidth
// to compatibility jamo conversion. Depends on hjn_pkg.
`timescale 1ns / 1ps

module hjn_front (
    input  logic          i_clk,
    input  logic          i_en,
    input  hjn_pkg::t_unit i_code_unit,
    input  logic          i_is_last,
    output hjn_pkg::t_s1  o_s1
);
    import hjn_pkg::*;

    logic       w_halfwidth;
    logic [7:0] w_lo;
    logic [7:0] w_ofs;
    logic       w_hangul;
    t_class     w_cls;
    t_s1        r_s1;
    t_s1        n_s1;

    // halfwidth offset by sub-range of the low byte
    always_comb begin
        w_halfwidth = (i_code_unit >= HW_LO) && (i_code_unit <= HW_HI);
        w_lo        = i_code_unit[7:0];
        if (w_lo < HW_BRK_0) begin
            w_ofs = HW_OFS_0;
        end else if (w_lo < HW_BRK_1) begin
            w_ofs = HW_OFS_1;
        end else if (w_lo < HW_BRK_2) begin
            w_ofs = HW_OFS_2;
        end else if (w_lo < HW_BRK_3) begin
            w_ofs = HW_OFS_3;
        end else begin
            w_ofs = HW_OFS_4;
        end
    end

    // script class
    always_comb begin
        w_hangul = (i_code_unit[15:8] == CONJ_HI_BYTE)
            || ((i_code_unit >= EXT_A_LO) && (i_code_unit <= EXT_A_HI))
            || ((i_code_unit >= EXT_B_LO) && (i_code_unit <= EXT_B_HI))
            || ((i_code_unit >= COMPAT_LO) && (i_code_unit <= COMPAT_HI))
            || w_halfwidth;
        if ((i_code_unit >= DIGIT_LO) && (i_code_unit <= DIGIT_HI)) begin
            w_cls = CLS_DIGIT;
        end else if ((i_code_unit >= ENG_LO) && (i_code_unit <= ENG_HI)) begin
            w_cls = CLS_ENGLISH;
        end else if (w_hangul) begin
            w_cls = CLS_HANGUL;
        end else begin
            w_cls = CLS_OTHER;
        end
    end

    always_comb begin
        n_s1.unit = w_halfwidth ? {COMPAT_HI_BYTE, w_lo - w_ofs} : i_code_unit;
        n_s1.cls  = w_cls;
        n_s1.last = i_is_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

/* hdl/hjn_index.sv */
// hjn_index: stage 2, compatibility jamo range check and table index.
// Depends on hjn_pkg.
`timescale 1ns / 1ps

module hjn_index (
    input  logic         i_clk,
    input  logic         i_en,
    input  hjn_pkg::t_s1 i_s1,
    output hjn_pkg::t_s2 o_s2
);
    import hjn_pkg::*;

    t_unit w_diff;
    t_s2   r_s2;
    t_s2   n_s2;

    // offset into the compatibility jamo block
    always_comb begin
        w_diff       = i_s1.unit - COMPAT_LO;
        n_s2.unit    = i_s1.unit;
        n_s2.idx     = w_diff[6:0];
        n_s2.in_jamo = (i_s1.unit >= COMPAT_LO) && (i_s1.unit <= COMPAT_HI);
        n_s2.cls     = i_s1.cls;
        n_s2.last    = i_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

/* hdl/hjn_lookup.sv */
// hjn_lookup: stage 3, conjoining jamo table lookup and output register.
// Depends on hjn_pkg.
`timescale 1ns / 1ps

module hjn_lookup (
    input  logic            i_clk,
    input  logic            i_en,
    input  hjn_pkg::t_s2    i_s2,
    output hjn_pkg::t_unit  o_unit,
    output hjn_pkg::t_class o_cls,
    output logic            o_last
);
    import hjn_pkg::*;

    t_unit  w_map;
    t_unit  r_unit;
    t_unit  n_unit;
    t_class r_cls;
    logic   r_last;

    // unmapped slots keep the compatibility unit
    always_comb begin
        w_map  = jamo_lookup(i_s2.idx);
        n_unit = (i_s2.in_jamo && (w_map != '0)) ? w_map : i_s2.unit;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= n_unit;
            r_cls  <= i_s2.cls;
            r_last <= i_s2.last;
        end
    end

    assign o_unit = r_unit;
    assign o_cls  = r_cls;
    assign o_last = r_last;

endmodule

/* hdl/hangul_jamo_normalizer_core.sv */
// hangul_jamo_normalizer_core: units pass the front, index and lookup registers.
// throughput one code unit per cycle unless the output stalls; the three register
// stages stall together behind the output register; each stage loads when empty or
// moves on. reset (synchronous, active low) clears the stage valid bits only.
// top level: valid tracking and stall control over hjn_front, hjn_index, hjn_lookup.
// depends on hjn_pkg, hjn_front, hjn_index and hjn_lookup.
`timescale 1ns / 1ps

module hangul_jamo_normalizer_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hjn_pkg::t_unit  i_code_unit,
    input  logic            i_is_last,
    output logic            o_valid,
    input  logic            i_ready,
    output hjn_pkg::t_unit  o_normalized_unit,
    output hjn_pkg::t_class o_script_class,
    output logic            o_last_out
);
    import hjn_pkg::*;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic w_en1;
    logic w_en2;
    logic w_en3;
    t_s1  w_s1;
    t_s2  w_s2;

    // a stage loads when it is empty or its transaction moves on
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v3;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    hjn_front u_front (
        .i_clk       (i_clk),
        .i_en        (w_en1),
        .i_code_unit (i_code_unit),
        .i_is_last   (i_is_last),
        .o_s1        (w_s1)
    );

    hjn_index u_index (
        .i_clk (i_clk),
        .i_en  (w_en2),
        .i_s1  (w_s1),
        .o_s2  (w_s2)
    );

    hjn_lookup u_lookup (
        .i_clk  (i_clk),
        .i_en   (w_en3),
        .i_s2   (w_s2),
        .o_unit (o_normalized_unit),
        .o_cls  (o_script_class),
        .o_last (o_last_out)
    );

endmodule

/* verif/hangul_jamo_normalizer_core_tb.sv */
// hangul_jamo_normalizer_core_tb: self-checking testbench for the jamo normalizer core.
// A scoreboard predicts each normalized unit and script class and checks results in order.
// Depends on hjn_pkg and hangul_jamo_normalizer_core.
`timescale 1ns / 1ps

module hangul_jamo_normalizer_core_tb;
    import hjn_pkg::*;

    localparam int          RANDOM_ITEMS = 700;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          LONG_HOLD    = 120;

    // conjoining jamo for compatibility jamo 3130+i, zero where no entry exists
    localparam t_unit COMPAT_TO_CONJ [0:95] = '{
        16'h0000, 16'h1100, 16'h1101, 16'h11AA, 16'h1102, 16'h11AC, 16'h11AD, 16'h1103,
        16'h1104, 16'h1105, 16'h11B0, 16'h11B1, 16'h11B2, 16'h11B3, 16'h11B4, 16'h11B5,
        16'h111A, 16'h1106, 16'h1107, 16'h1108, 16'h1121, 16'h1109, 16'h110A, 16'h110B,
        16'h110C, 16'h110D, 16'h110E, 16'h110F, 16'h1110, 16'h1111, 16'h1112, 16'h1161,
        16'h1162, 16'h1163, 16'h1164, 16'h1165, 16'h1166, 16'h1167, 16'h1168, 16'h1169,
        16'h116A, 16'h116B, 16'h116C, 16'h116D, 16'h116E, 16'h116F, 16'h1170, 16'h1171,
        16'h1172, 16'h1173, 16'h1174, 16'h1175, 16'h1160, 16'h1114, 16'h1115, 16'h11C7,
        16'h11C8, 16'h11CC, 16'h11CE, 16'h11D3, 16'h11D7, 16'h11D9, 16'h111C, 16'h11DD,
        16'h11DF, 16'h111D, 16'h111E, 16'h1120, 16'h1122, 16'h1123, 16'h1127, 16'h1129,
        16'h112B, 16'h112C, 16'h112D, 16'h112E, 16'h112F, 16'h1132, 16'h1136, 16'h1140,
        16'h1147, 16'h114C, 16'h11F1, 16'h11F2, 16'h1157, 16'h1158, 16'h1159, 16'h1184,
        16'h1185, 16'h1188, 16'h1191, 16'h1192, 16'h1194, 16'h119E, 16'h11A1, 16'h0000
    };

    // range edges used to aim random units at class and mapping boundaries
    localparam t_unit RANGE_EDGES [0:13] = '{
        16'h0030, 16'h0039, 16'h0041, 16'h007A, 16'h1100, 16'h11FF, 16'hA960,
        16'hA97F, 16'hD7B0, 16'hD7FF, 16'h3130, 16'h318F, 16'hFFA0, 16'hFFDC
    };

    // directed units: field extremes, class edges, halfwidth offset bands, special finals
    localparam t_unit DIRECTED_UNITS [0:24] = '{
        16'h0000, 16'hFFFF, 16'h0030, 16'h0039, 16'h0041, 16'h007A, 16'h0040,
        16'h007B, 16'h1100, 16'h11FF, 16'hA960, 16'hA97F, 16'hD7B0, 16'hD7FF,
        16'h3130, 16'h318F, 16'hFFA0, 16'hFFDC, 16'hFFBE, 16'hFFBF, 16'hFFC8,
        16'hFFD0, 16'hFFD8, 16'h316F, 16'h3183
    };

    typedef struct packed {
        t_unit  unit;
        t_class cls;
        logic   last;
    } t_norm_result;

    // predicts each accepted unit and checks results in arrival order
    class jamo_scoreboard;
        t_norm_result pending_units[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function t_norm_result predict_unit(t_unit u, logic last);
            t_norm_result r;
            t_unit        v;
            logic [7:0]   lo;
            v = u;
            // halfwidth hangul shifts into the compatibility block by band
            if (u >= HW_LO && u <= HW_HI) begin
                lo = u[7:0];
                if (lo < 8'hBF)      lo = lo - 8'h70;
                else if (lo < 8'hC8) lo = lo - 8'h73;
                else if (lo < 8'hD0) lo = lo - 8'h75;
                else if (lo < 8'hD8) lo = lo - 8'h77;
                else                 lo = lo - 8'h79;
                v = {8'h31, lo};
            end
            // compatibility jamo to conjoining jamo, unmapped slots stay put
            if (v >= COMPAT_LO && v <= COMPAT_HI) begin
                if (COMPAT_TO_CONJ[v - COMPAT_LO] != 16'h0000)
                    v = COMPAT_TO_CONJ[v - COMPAT_LO];
            end
            r.unit = v;
            // class follows the original unit
            if (u >= DIGIT_LO && u <= DIGIT_HI)
                r.cls = CLS_DIGIT;
            else if (u >= ENG_LO && u <= ENG_HI)
                r.cls = CLS_ENGLISH;
            else if (u[15:8] == CONJ_HI_BYTE || (u >= EXT_A_LO && u <= EXT_A_HI)
                     || (u >= EXT_B_LO && u <= EXT_B_HI)
                     || (u >= COMPAT_LO && u <= COMPAT_HI) || (u >= HW_LO && u <= HW_HI))
                r.cls = CLS_HANGUL;
            else
                r.cls = CLS_OTHER;
            r.last = last;
            return r;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatch_count++;
        endtask

        task note_input(t_unit u, logic last);
            pending_units.push_back(predict_unit(u, last));
        endtask

        task check_result(t_unit u, t_class c, logic last);
            t_norm_result e;
            if (pending_units.size() == 0) begin
                report($sformatf("unexpected transaction unit=%h class=%0d", u, c));
                return;
            end
            e = pending_units.pop_front();
            if (u !== e.unit)
                report($sformatf("normalized_unit got %h expected %h", u, e.unit));
            if (c !== e.cls)
                report($sformatf("script_class got %0d expected %0d (unit %h)", c, e.cls, u));
            if (last !== e.last)
                report($sformatf("last_out got %b expected %b (unit %h)", last, e.last, u));
        endtask
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_unit  i_code_unit;
    logic   i_is_last;
    logic   o_valid;
    logic   i_ready;
    t_unit  o_normalized_unit;
    t_class o_script_class;
    logic   o_last_out;

    jamo_scoreboard scoreboard = new();
    bit             stim_done  = 1'b0;
    int             cycle_count = 0;

    hangul_jamo_normalizer_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_code_unit       (i_code_unit),
        .i_is_last         (i_is_last),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_normalized_unit (o_normalized_unit),
        .o_script_class    (o_script_class),
        .o_last_out        (o_last_out)
    );

    always #2 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // monitor both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            scoreboard.note_input(i_code_unit, i_is_last);
        if (i_rst_n && o_valid && i_ready)
            scoreboard.check_result(o_normalized_unit, o_script_class, o_last_out);
    end

    // random unit weighted toward the hangul ranges and class edges
    function automatic t_unit random_unit();
        t_unit u;
        case ($urandom_range(0, 9))
            0, 1, 2: u = COMPAT_LO + t_unit'($urandom_range(0, 95));
            3, 4:    u = HW_LO + t_unit'($urandom_range(0, 60));
            5: begin
                case ($urandom_range(0, 2))
                    0:       u = 16'h1100 + t_unit'($urandom_range(0, 255));
                    1:       u = EXT_A_LO + t_unit'($urandom_range(0, 31));
                    default: u = EXT_B_LO + t_unit'($urandom_range(0, 79));
                endcase
            end
            6:       u = t_unit'($urandom_range(0, 127));
            7:       u = RANGE_EDGES[$urandom_range(0, 13)] + t_unit'($urandom_range(0, 4))
                         - 16'd2;
            default: u = t_unit'($urandom_range(0, 65535));
        endcase
        return u;
    endfunction

    // offer one transaction, hold until accepted, then optionally idle
    task automatic send_unit(input t_unit u, input logic last, input int unsigned gap);
        i_valid     <= 1'b1;
        i_code_unit <= u;
        i_is_last   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver stall pattern, with one long hold-off to back up the pipeline
    initial begin
        int          segment;
        int unsigned mode;
        int unsigned seg_len;
        int unsigned cyc;
        segment = 0;
        i_ready <= 1'b0;
        while (!stim_done) begin
            segment++;
            if (segment == 6) begin
                i_ready <= 1'b0;
                for (cyc = 0; cyc < LONG_HOLD; cyc++) @(posedge i_clk);
            end else begin
                mode    = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 60);
                for (cyc = 0; cyc < seg_len; cyc++) begin
                    case (mode)
                        0:       i_ready <= 1'b1;
                        1:       i_ready <= 1'($urandom_range(0, 1));
                        2:       i_ready <= (cyc % 4 != 3);
                        default: i_ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
        i_ready <= 1'b1;
    end

    // reset, directed units, random bursts, drain, verdict
    initial begin
        int          idx;
        int          sent;
        int unsigned burst;
        int unsigned gap;
        int unsigned k;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_code_unit <= '0;
        i_is_last   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < 25; idx++)
            send_unit(DIRECTED_UNITS[idx], idx[0], (idx % 5 == 4) ? 2 : 0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                if (k == burst - 1 && $urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, 10);
                else
                    gap = 0;
                send_unit(random_unit(), ($urandom_range(0, 3) == 0), gap);
                sent++;
            end
        end
        i_valid   <= 1'b0;
        stim_done = 1'b1;

        while (scoreboard.pending_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
